[sv/spq_pkg.sv]
// Types and codes shared by the sorted priority queue modules.
package spq_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TRAV = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_TRAV = 1'b1
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] priority_req;
    logic signed [15:0] payload;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] out_priority;
    logic signed [15:0] out_payload;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [15:0] data;
  } entry_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    cell_op_e           op;
    entry_t             new_entry;
    entry_t             head;
  } cell_ctl_t;

endpackage

[sv/spq_cell.sv]
// One storage cell of the sorted chain: holds one entry and shifts with its neighbors.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic signed [15:0] key,
  input  logic               occ,
  input  logic               occ_right,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_le,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               le,
  output logic               eq
);

  spq_pkg::entry_t entry_next;
  logic            ge;

  // Compare stored priority against the request key
  assign le = occ && (entry.prio <= key);
  assign ge = occ && (entry.prio >= key);
  assign eq = occ && (entry.prio == key);

  // Pick the next content from the command and the neighbors
  always_comb begin
    entry_next = entry;
    case (ctl.op)
      spq_pkg::OP_INS: begin
        if (!le) begin
          entry_next = left_le ? ctl.new_entry : left_entry;
        end
      end
      spq_pkg::OP_DEL: begin
        if (ge) begin
          entry_next = right_entry;
        end
      end
      spq_pkg::OP_ROT: begin
        if (occ) begin
          entry_next = occ_right ? right_entry : ctl.head;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[sv/sorted_priority_queue.sv]
// Sorted priority queue: top level with command sequencer, cell chain and result register.
//
// Request channel (req_valid/req_ready/req_data) takes one command per beat:
// enqueue, delete by priority, or traverse. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns result beats from a single output
// register. Entries are held in a chain of CAPACITY cells in ascending
// priority order, ties in arrival order.
// Enqueue and delete finish in the cycle they are accepted: the cells past the
// insert or delete point shift toward or away from their neighbor at once, and
// the status beat shows on the next cycle. One such command can be taken per
// cycle while the receiver keeps up.
// Traverse of N entries gives N beats, one per cycle while the receiver keeps
// up, by rotating the chain one place per beat through the head cell; the
// chain is back in order after the last beat. No new request is taken until
// that beat is loaded. An empty queue gives one empty-status beat.
// Reset clears the entry count and the result valid flag; cell contents are
// not cleared and are never shown before being written.
// When the receiver stalls, the result beat holds and req_ready drops until
// the output register is free again.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  spq_pkg::req_t  req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output spq_pkg::rsp_t  rsp_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::state_e    state;
  spq_pkg::state_e    state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   remain;
  logic [CNT_W-1:0]   remain_next;
  logic               rsp_valid_next;
  spq_pkg::rsp_t      rsp_next;
  spq_pkg::cell_ctl_t ctl;
  logic signed [15:0] cell_key;

  spq_pkg::entry_t    cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] cell_occ;

  logic slot_free;
  logic accept;
  logic found;
  logic full;
  logic empty;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == spq_pkg::ST_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign found     = |cell_eq;
  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign cell_key  = req_data.priority_req;

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_le;
    logic            occ_right;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_le    = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[i-1];
      assign left_le    = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
      assign occ_right   = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign occ_right   = cell_occ[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (cell_key),
      .occ         (cell_occ[i]),
      .occ_right   (occ_right),
      .left_entry  (left_entry),
      .left_le     (left_le),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .le          (cell_le[i]),
      .eq          (cell_eq[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept && req_data.kind == spq_pkg::KIND_TRAV && !empty) begin
          state_next = spq_pkg::ST_TRAV;
        end
      end
      spq_pkg::ST_TRAV: begin
        if (slot_free && remain == CNT_W'(1)) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Drive cell commands, count, and the result beat
  always_comb begin
    ctl.op         = spq_pkg::OP_HOLD;
    ctl.new_entry  = '{prio: req_data.priority_req, data: req_data.payload};
    ctl.head       = cell_entry[0];
    count_next     = count;
    remain_next    = remain;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp_data;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_next = '{status: spq_pkg::STAT_OK, out_priority: '0,
                       out_payload: '0, last: 1'b1};
          case (req_data.kind)
            spq_pkg::KIND_ENQ: begin
              rsp_valid_next = 1'b1;
              if (full) begin
                rsp_next.status = spq_pkg::STAT_FULL;
              end else begin
                ctl.op     = spq_pkg::OP_INS;
                count_next = count + CNT_W'(1);
              end
            end
            spq_pkg::KIND_DEL: begin
              rsp_valid_next = 1'b1;
              if (empty) begin
                rsp_next.status = spq_pkg::STAT_EMPTY;
              end else if (!found) begin
                rsp_next.status = spq_pkg::STAT_NOTFOUND;
              end else begin
                ctl.op     = spq_pkg::OP_DEL;
                count_next = count - CNT_W'(1);
              end
            end
            spq_pkg::KIND_TRAV: begin
              if (empty) begin
                rsp_valid_next  = 1'b1;
                rsp_next.status = spq_pkg::STAT_EMPTY;
              end else begin
                remain_next = count;
              end
            end
            default: begin
              rsp_next = rsp_data;
            end
          endcase
        end
      end
      spq_pkg::ST_TRAV: begin
        if (slot_free) begin
          ctl.op         = spq_pkg::OP_ROT;
          rsp_valid_next = 1'b1;
          rsp_next       = '{status: spq_pkg::STAT_OK,
                             out_priority: cell_entry[0].prio,
                             out_payload: cell_entry[0].data,
                             last: (remain == CNT_W'(1))};
          remain_next    = remain - CNT_W'(1);
        end
      end
      default: begin
        ctl.op = spq_pkg::OP_HOLD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remain    <= remain_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    rsp_data <= rsp_next;
  end

endmodule

[sv/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp_data
);

  // Hold a stalled result beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat changed while stalled");

  // Close every error beat as the final one
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != spq_pkg::STAT_OK |-> rsp_data.last)
    else $error("error status without last");

  // Zero the entry fields on error beats
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != spq_pkg::STAT_OK |->
      rsp_data.out_priority == '0 && rsp_data.out_payload == '0)
    else $error("error status with entry data");

  // Drop results on reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
